// File: design/ptrs_pkg.sv
// Package for the periodic task release scheduler.
// Holds the word types, request and state codes, and the modulo unit status.
// No dependencies.
`timescale 1ns / 1ps

package ptrs_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int TICK_W         = 32;
  localparam int MASK_W         = 8;
  localparam int VAL_W          = 8;
  localparam int IDX_W          = 3;
  localparam int REQ_W          = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_CREATE   = 3'd1,
    REQ_DELETE   = 3'd2,
    REQ_SUSPEND  = 3'd3,
    REQ_ACTIVATE = 3'd4,
    REQ_DELAY    = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] task_index;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] first_offset;
    logic [VAL_W-1:0] delay_ticks;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] release_mask;
    logic [TICK_W-1:0] tick_now;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;      // last step of the current remainder
    logic rem_zero;  // valid with done
  } mod_status_t;

endpackage

// File: design/ptrs_mod.sv
// Bit-serial remainder unit: tick counter modulo an 8-bit divisor.
// One restoring step per cycle, dividend bits taken MSB first.
// Depends on ptrs_pkg.
`timescale 1ns / 1ps

module ptrs_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ptrs_pkg::TICK_W-1:0] dividend_i,
  input  logic [ptrs_pkg::VAL_W-1:0]  divisor_i,
  output ptrs_pkg::mod_status_t     status_o
);
  import ptrs_pkg::*;

  localparam int CNT_W = $clog2(TICK_W);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(TICK_W - 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TICK_W-1:0] dvd_q;
  logic [VAL_W-1:0]  div_q;
  logic [VAL_W-1:0]  rem_q;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;
  logic [VAL_W-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[TICK_W-1]};
    diff  = trial - {1'b0, div_q};
    // remainder stays below the divisor, so it fits in VAL_W bits
    if (trial >= {1'b0, div_q}) begin
      rem_d = diff[VAL_W-1:0];
    end else begin
      rem_d = trial[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign status_o.busy     = busy_q;
  assign status_o.done     = busy_q && (cnt_q == LastStep);
  assign status_o.rem_zero = (rem_d == '0);

endmodule

// File: design/periodic_task_release_scheduler.sv
// Periodic task release scheduler: command and tick word in, one result word out.
// A command word goes from idle straight to the finish state. A tick word scans
// every slot in turn: each present, active, non-delayed slot with a nonzero
// divisor runs one 32-step remainder in the shared bit-serial modulo unit, one
// slot after another, and the other slots are settled without it. Input ready is
// high only between words; a finished result waits in the output register while
// the next word is taken.
// Depends on ptrs_pkg and ptrs_mod.
`timescale 1ns / 1ps

module periodic_task_release_scheduler #(
  parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptrs_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptrs_pkg::out_word_t out_data_o
);
  import ptrs_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(TASK_SLOTS - 1);

  state_e            state_q, state_d;
  logic [TICK_W-1:0] tick_q;
  logic [SLOT_W-1:0] scan_q;
  logic [MASK_W-1:0] mask_q;
  logic              is_tick_q;
  out_word_t         out_q;
  logic              out_valid_q;

  logic [VAL_W-1:0] slot_period_q  [TASK_SLOTS];
  logic [VAL_W-1:0] slot_first_q   [TASK_SLOTS];
  logic [VAL_W-1:0] slot_hold_q    [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] first_pend_q;
  logic [TASK_SLOTS-1:0] holding_q;
  logic [TASK_SLOTS-1:0] active_q;
  logic [TASK_SLOTS-1:0] present_q;

  logic             accept;
  logic             slot_live;
  logic [VAL_W-1:0] divisor;
  logic             mod_start;
  logic             advance;
  logic             fire;
  logic             out_load;
  mod_status_t      mod_stat;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_live = present_q[scan_q] && active_q[scan_q];
  assign divisor   = first_pend_q[scan_q] ? slot_first_q[scan_q] : slot_period_q[scan_q];
  assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mod_start  = 1'b0;
    advance    = 1'b0;
    fire       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (in_data_i.req_type == REQ_TICK) ? ST_SLOT : ST_FINISH;
        end
      end
      ST_SLOT: begin
        // held, idle or zero-divisor slots are settled in this cycle
        if (slot_live && !holding_q[scan_q] && (divisor != '0)) begin
          mod_start = 1'b1;
          state_d   = ST_WAIT;
        end else begin
          advance = 1'b1;
        end
      end
      ST_WAIT: begin
        if (mod_stat.done) begin
          advance = 1'b1;
          fire    = mod_stat.rem_zero;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (advance) begin
      state_d = (scan_q == LastSlot) ? ST_FINISH : ST_SLOT;
    end
  end

  ptrs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (tick_q),
    .divisor_i  (divisor),
    .status_o   (mod_stat)
  );

  // tick counter, scan position, release mask, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      scan_q      <= '0;
      mask_q      <= '0;
      is_tick_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        is_tick_q <= (in_data_i.req_type == REQ_TICK);
        mask_q    <= '0;
        scan_q    <= '0;
        if (in_data_i.req_type == REQ_TICK) begin
          tick_q <= tick_q + 1'b1;
        end
      end
      if (advance && (scan_q != LastSlot)) begin
        scan_q <= scan_q + 1'b1;
      end
      for (int k = 0; k < MASK_W; k++) begin
        if (fire && (32'(scan_q) == k)) begin
          mask_q[k] <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.release_mask <= mask_q;
      out_q.tick_now     <= tick_q;
    end
  end

  // slot table: commands write at the addressed slot, the scan at its own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pend_q <= '0;
      holding_q    <= '0;
      active_q     <= '0;
      present_q    <= '0;
      for (int s = 0; s < TASK_SLOTS; s++) begin
        slot_period_q[s] <= '0;
        slot_first_q[s]  <= '0;
        slot_hold_q[s]   <= '0;
      end
    end else begin
      for (int s = 0; s < TASK_SLOTS; s++) begin
        if (accept && (32'(in_data_i.task_index) == s)) begin
          case (in_data_i.req_type)
            REQ_CREATE: begin
              slot_period_q[s] <= in_data_i.period;
              slot_first_q[s]  <= in_data_i.first_offset;
              first_pend_q[s]  <= (in_data_i.first_offset != '0);
              holding_q[s]     <= 1'b0;
              slot_hold_q[s]   <= '0;
              present_q[s]     <= 1'b1;
            end
            REQ_DELETE: begin
              present_q[s] <= 1'b0;
            end
            REQ_SUSPEND: begin
              active_q[s] <= 1'b0;
            end
            REQ_ACTIVATE: begin
              active_q[s] <= 1'b1;
            end
            REQ_DELAY: begin
              slot_hold_q[s] <= in_data_i.delay_ticks;
              holding_q[s]   <= (in_data_i.delay_ticks != '0);
            end
            default: begin
            end
          endcase
        end
        if (32'(scan_q) == s) begin
          if ((state_q == ST_SLOT) && slot_live && holding_q[s]) begin
            slot_hold_q[s] <= slot_hold_q[s] - 1'b1;
            if (slot_hold_q[s] == VAL_W'(1)) begin
              holding_q[s] <= 1'b0;
            end
          end
          if (fire) begin
            first_pend_q[s] <= 1'b0;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // the modulo unit only runs while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_stat.busy |-> (state_q == ST_WAIT))
    else $error("modulo unit busy outside wait state");

  // command words never release anything
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && !is_tick_q) |-> (mask_q == '0))
    else $error("release mask set for a command word");

  // an accepted word always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");
`endif

endmodule

// File: bench/tb.sv
// Testbench for periodic_task_release_scheduler: directed and random command/tick words.
// Predicts every result word in-bench, checks in order, stalls both sides at random.
// Depends on ptrs_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb;
  import ptrs_pkg::*;

  localparam int SLOTS       = TASK_SLOTS_DEF;
  localparam int TICK_LAT    = 2 + 33 * SLOTS;  // worst case tick word
  localparam int STALL_LEN   = 2000;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  periodic_task_release_scheduler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scheduler state as seen by the bench
  logic [TICK_W-1:0] tick_cnt = '0;
  logic [VAL_W-1:0]  per_q   [SLOTS] = '{default: '0};
  logic [VAL_W-1:0]  first_q [SLOTS] = '{default: '0};
  logic [VAL_W-1:0]  hold_q  [SLOTS] = '{default: '0};
  logic              first_pend [SLOTS] = '{default: 1'b0};
  logic              holding    [SLOTS] = '{default: 1'b0};
  logic              active     [SLOTS] = '{default: 1'b0};
  logic              present    [SLOTS] = '{default: 1'b0};

  out_word_t due_words[$];
  out_word_t due_w;

  int errors      = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_ticks     = 0;
  int n_released  = 0;
  int cycle_cnt   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_off = 1'b0;
  event stall_ev;

  // Applies one word to the bench's copy of the slot table.
  function automatic out_word_t schedule_step(input in_word_t w);
    out_word_t        r;
    logic [MASK_W-1:0] fired;
    int               s;
    fired = '0;
    case (w.req_type)
      REQ_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        for (s = 0; s < SLOTS; s++) begin
          if (present[s] && active[s]) begin
            if (holding[s]) begin
              hold_q[s] = hold_q[s] - 1'b1;
              if (hold_q[s] == '0) holding[s] = 1'b0;
            end else if (first_pend[s]) begin
              if (first_q[s] != '0 && (tick_cnt % first_q[s]) == '0) begin
                fired[s]      = 1'b1;
                first_pend[s] = 1'b0;
              end
            end else if (per_q[s] != '0 && (tick_cnt % per_q[s]) == '0) begin
              fired[s] = 1'b1;
            end
          end
        end
      end
      REQ_CREATE: begin
        per_q[w.task_index]      = w.period;
        first_q[w.task_index]    = w.first_offset;
        first_pend[w.task_index] = (w.first_offset != '0);
        holding[w.task_index]    = 1'b0;
        hold_q[w.task_index]     = '0;
        present[w.task_index]    = 1'b1;
      end
      REQ_DELETE:   present[w.task_index] = 1'b0;
      REQ_SUSPEND:  active[w.task_index] = 1'b0;
      REQ_ACTIVATE: active[w.task_index] = 1'b1;
      REQ_DELAY: begin
        hold_q[w.task_index]  = w.delay_ticks;
        holding[w.task_index] = (w.delay_ticks != '0);
      end
      default: ;  // unused codes change nothing
    endcase
    r.release_mask = fired;
    r.tick_now     = tick_cnt;
    return r;
  endfunction

  // Input and output monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        due_words.push_back(schedule_step(in_data_i));
        n_sent++;
        if (in_data_i.req_type == REQ_TICK) n_ticks++;
      end
      if (out_valid_o && out_ready_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_data_o);
          errors++;
        end else begin
          due_w = due_words.pop_front();
          n_checked++;
          n_released += $countones(out_data_o.release_mask);
          if (out_data_o.release_mask !== due_w.release_mask) begin
            $display("%0t: release_mask mismatch, expected %h, actual %h",
                     $time, due_w.release_mask, out_data_o.release_mask);
            errors++;
          end
          if (out_data_o.tick_now !== due_w.tick_now) begin
            $display("%0t: tick_now mismatch, expected %0d, actual %0d",
                     $time, due_w.tick_now, out_data_o.tick_now);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else          out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial forever begin
    @(stall_ev);
    @(posedge clk_i) hold_off <= 1'b1;
    repeat (STALL_LEN) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("periodic_task_release_scheduler verification failed");
      $finish;
    end
  end

  // Valid stays high after acceptance; only an idle cycle lowers it.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // One edge first so the monitor has queued the last accepted word.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (TICK_LAT) @(posedge clk_i);
  endtask

  function automatic in_word_t mk(input logic [REQ_W-1:0] req, input int idx,
                                  input int per, input int first, input int dly);
    in_word_t w;
    w.req_type     = req;
    w.task_index   = IDX_W'(idx);
    w.period       = VAL_W'(per);
    w.first_offset = VAL_W'(first);
    w.delay_ticks  = VAL_W'(dly);
    return w;
  endfunction

  // Tick heavy mix, mostly short periods so releases actually happen.
  function automatic in_word_t rand_word();
    in_word_t w;
    int       pick;
    w.task_index   = IDX_W'($urandom_range(SLOTS - 1));
    w.period       = VAL_W'($urandom);
    w.first_offset = VAL_W'($urandom);
    w.delay_ticks  = VAL_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      w.req_type = REQ_TICK;
    end else if (pick < 60) begin
      w.req_type = REQ_CREATE;
      pick = $urandom_range(99);
      if (pick < 70)      w.period = VAL_W'($urandom_range(12, 1));
      else if (pick < 80) w.period = '0;
      pick = $urandom_range(99);
      if (pick < 40)      w.first_offset = '0;
      else if (pick < 80) w.first_offset = VAL_W'($urandom_range(16, 1));
    end else if (pick < 65) begin
      w.req_type = REQ_DELETE;
    end else if (pick < 72) begin
      w.req_type = REQ_SUSPEND;
    end else if (pick < 85) begin
      w.req_type = REQ_ACTIVATE;
    end else if (pick < 95) begin
      w.req_type = REQ_DELAY;
      pick = $urandom_range(99);
      if (pick < 60)      w.delay_ticks = VAL_W'($urandom_range(6, 1));
      else if (pick < 70) w.delay_ticks = '0;
    end else begin
      w.req_type = REQ_W'($urandom_range(7, 6));
    end
    return w;
  endfunction

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(mk(REQ_TICK, 0, 0, 0, 0));           // empty table
    send_word(mk(REQ_CREATE, 0, 1, 0, 0));
    send_word(mk(REQ_TICK, 0, 0, 0, 0));           // present but suspended
    send_word(mk(REQ_ACTIVATE, 0, 0, 0, 0));
    send_word(mk(REQ_TICK, 0, 0, 0, 0));
    send_word(mk(REQ_CREATE, 7, 255, 1, 255));     // first offset of one
    send_word(mk(REQ_ACTIVATE, 7, 0, 0, 0));
    send_word(mk(REQ_TICK, 7, 255, 255, 255));
    send_word(mk(REQ_DELAY, 0, 0, 0, 2));
    send_word(mk(REQ_TICK, 0, 0, 0, 0));           // held
    send_word(mk(REQ_TICK, 0, 0, 0, 0));           // hold runs out
    send_word(mk(REQ_TICK, 0, 0, 0, 0));
    send_word(mk(REQ_DELAY, 7, 0, 0, 0));          // zero delay clears hold
    send_word(mk(REQ_CREATE, 3, 0, 0, 0));         // period zero
    send_word(mk(REQ_ACTIVATE, 3, 0, 0, 0));
    send_word(mk(REQ_ACTIVATE, 4, 0, 0, 0));       // absent slot
    send_word(mk(REQ_DELAY, 4, 0, 0, 255));
    send_word(mk(REQ_CREATE, 4, 2, 255, 0));       // create drops the hold
    send_word(mk(REQ_TICK, 0, 0, 0, 0));
    send_word(mk(REQ_DELETE, 0, 0, 0, 0));
    send_word(mk(REQ_SUSPEND, 7, 0, 0, 0));
    send_word(mk(REQ_W'(6), 5, 255, 255, 255));    // unused codes
    send_word(mk(REQ_W'(7), 2, 255, 255, 255));
    send_word(mk(REQ_TICK, 0, 0, 0, 0));
    send_word(mk(REQ_TICK, 0, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_random_mix(input int n_words, input int s_pct, input int r_pct);
    in_word_t w;
    int       cnt;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    cnt = 0;
    while (cnt < n_words) begin
      w = rand_word();
      send_word(w);
      if (w.req_type <= REQ_DELAY) cnt++;
    end
    wait_idle();
  endtask

  // Output held off while words keep coming: the block must back up its input.
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> stall_ev;
    for (i = 0; i < 30; i++) send_word(rand_word());
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_mix(350, 38, 72);
    test_random_mix(350, 72, 38);
    test_backpressure();
    test_random_mix(350, 0, 0);
    $display("Sent %0d words (%0d ticks), checked %0d results, saw %0d slot releases.",
             n_sent, n_ticks, n_checked, n_released);
    if (errors == 0) begin
      $display("periodic_task_release_scheduler verification clean");
    end else begin
      $display("periodic_task_release_scheduler verification failed");
    end
    $finish;
  end

endmodule
